@@ design/hdq_pkg.sv @@
`timescale 1ns / 1ps

package hdq_pkg;

  localparam int REG_COUNT_DEF = 128;
  localparam int ADDR_W        = 7;
  localparam int CAP_W         = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CAP_W-1:0] GLITCH_RESET = 16'd10;
  localparam logic [CAP_W-1:0] BREAK_RESET  = 16'd190;
  localparam logic [CAP_W-1:0] ONE_RESET    = 16'd50;

  localparam logic [7:0] WRITE_FLAG = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLITCH = 2'd0,
    CFG_BREAK  = 2'd1,
    CFG_ONE    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_BRK_FALL = 2'd0,
    PH_BRK_RISE = 2'd1,
    PH_DAT_FALL = 2'd2,
    PH_DAT_RISE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_BREAK   = 3'd1,
    EV_WCMD    = 3'd2,
    EV_WRITTEN = 3'd3,
    EV_READ    = 3'd4
  } event_t;

  typedef struct packed {
    logic [CAP_W-1:0] glitch_limit;
    logic [CAP_W-1:0] break_limit;
    logic [CAP_W-1:0] one_limit;
  } limits_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    event_t            ev;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              rd;
  } rx_res_t;

  localparam logic [7:0] INIT_IMAGE [128] = '{
    8'h00,8'h00,8'h01,8'h00,8'h01,8'h00,8'h04,8'h9c,8'h0f,8'ha0,8'h10,8'h3c,8'h03,8'he8,8'h03,8'he8,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15
  };

endpackage

@@ design/hdq_if.sv @@
`timescale 1ns / 1ps

interface hdq_in_if
  import hdq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capture_us;

  modport source (output valid, output capture_us, input ready);
  modport sink (input valid, input capture_us, output ready);
endinterface

interface hdq_out_if
  import hdq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        event_res;
  logic [ADDR_W-1:0] reg_address;
  logic [7:0]        reg_data;

  modport source (output valid, output event_res, output reg_address, output reg_data,
                  input ready);
  modport sink (input valid, input event_res, input reg_address, input reg_data,
                output ready);
endinterface

interface hdq_cfg_if
  import hdq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAP_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/hdq_rx.sv @@
`timescale 1ns / 1ps

module hdq_rx
  import hdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [CAP_W-1:0] capture_us,
  input  limits_t          limits,
  output rx_res_t          res,
  output mem_req_t         req
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        after_r, after_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  byte_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BRK_FALL;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      after_r <= 1'b0;
      cmd_r   <= 8'd0;
    end else if (en) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      after_r <= after_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    after_nxt = after_r;
    cmd_nxt   = cmd_r;
    byte_v    = shift_r;
    res.ev    = EV_NONE;
    res.data  = 8'd0;
    res.rd    = 1'b0;
    req.wr_en = 1'b0;
    req.wdata = 8'd0;
    if (capture_us > limits.glitch_limit) begin
      case (phase_r)
        PH_BRK_FALL: begin
          phase_nxt = PH_BRK_RISE;
        end
        PH_BRK_RISE: begin
          if (capture_us > limits.break_limit) begin
            phase_nxt = PH_DAT_FALL;
            bit_nxt   = 3'd0;
            shift_nxt = 8'd0;
            after_nxt = 1'b0;
            res.ev    = EV_BREAK;
          end else begin
            phase_nxt = PH_BRK_FALL;
          end
        end
        PH_DAT_FALL: begin
          phase_nxt = PH_DAT_RISE;
        end
        default: begin
          if (capture_us <= limits.break_limit) begin
            phase_nxt = PH_DAT_FALL;
            if (capture_us < limits.one_limit) begin
              byte_v = shift_r | (8'd1 << bit_r);
            end
            shift_nxt = byte_v;
            if (bit_r != 3'd7) begin
              bit_nxt = bit_r + 3'd1;
            end else begin
              bit_nxt   = 3'd0;
              shift_nxt = 8'd0;
              after_nxt = 1'b1;
              if (!after_r) begin
                cmd_nxt = byte_v;
              end
              if ((cmd_nxt & WRITE_FLAG) != 8'd0) begin
                if (after_r) begin
                  res.ev    = EV_WRITTEN;
                  res.data  = byte_v;
                  req.wr_en = 1'b1;
                  req.wdata = byte_v;
                end else begin
                  res.ev = EV_WCMD;
                end
              end else begin
                res.ev = EV_READ;
                res.rd = 1'b1;
              end
            end
          end else begin
            phase_nxt = PH_BRK_FALL;
          end
        end
      endcase
    end
    res.addr  = cmd_nxt[ADDR_W-1:0];
    req.addr  = cmd_nxt[ADDR_W-1:0];
    req.rd_en = res.rd & en;
    req.wr_en = req.wr_en & en;
  end

endmodule

@@ design/hdq_regfile.sv @@
`timescale 1ns / 1ps

module hdq_regfile
  import hdq_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [7:0]           mem_q_r;
  logic [7:0]           init_r;
  logic                 hit_r;
  logic                 range_r;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;

  assign idx      = req.addr[IDX_W-1:0];
  assign in_range = {1'b0, req.addr} < (ADDR_W + 1)'(REG_COUNT);

  always_ff @(posedge clk) begin
    if (req.wr_en && in_range) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[idx];
      init_r  <= INIT_IMAGE[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
      range_r <= 1'b0;
    end else begin
      if (req.wr_en && in_range) begin
        valid_r[idx] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r   <= valid_r[idx];
        range_r <= in_range;
      end
    end
  end

  assign rd_data = !range_r ? 8'd0 : (hit_r ? mem_q_r : init_r);

endmodule

@@ design/hdq_slave_register_interface.sv @@
`timescale 1ns / 1ps

// HDQ slave register interface. One edge capture is taken per clock cycle when the output
// side keeps up. A request is decoded, and its register-file read issued, at the edge that
// accepts it; the result moves from the decode stage into the output register once that
// register is empty or being drained, and leaves when the sink is ready. The registered
// read of the register file sits between the decode stage and the output register. While a
// result waits at the output, one further request can be taken into the decode stage; after
// that the input stalls until the output drains. The register file is restored to its
// initial image at reset at once, through one valid flag per entry, so no clearing pass is
// needed. Limits are written through the configuration channel, which is always ready.

module hdq_slave_register_interface
  import hdq_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hdq_in_if.sink    in_chan,
  hdq_out_if.source out_chan,
  hdq_cfg_if.sink   cfg_chan
);

  limits_t  limits_r;
  rx_res_t  rx_res;
  mem_req_t req;
  logic [7:0] rd_data;

  rx_res_t    s1_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  event_t     out_ev_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [7:0] out_data_r;
  logic       s1_move;
  logic       accept;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.glitch_limit <= GLITCH_RESET;
      limits_r.break_limit  <= BREAK_RESET;
      limits_r.one_limit    <= ONE_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_GLITCH: limits_r.glitch_limit <= cfg_chan.data;
        CFG_BREAK:  limits_r.break_limit  <= cfg_chan.data;
        CFG_ONE:    limits_r.one_limit    <= cfg_chan.data;
        default:    limits_r <= limits_r;
      endcase
    end
  end

  assign s1_move       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign accept        = in_chan.valid && in_chan.ready;

  hdq_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (accept),
    .capture_us (in_chan.capture_us),
    .limits     (limits_r),
    .res        (rx_res),
    .req        (req)
  );

  hdq_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= rx_res;
    end
    if (s1_move) begin
      out_ev_r   <= s1_r.ev;
      out_addr_r <= s1_r.addr;
      out_data_r <= s1_r.rd ? rd_data : s1_r.data;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_res   = out_ev_r;
  assign out_chan.reg_address = out_addr_r;
  assign out_chan.reg_data    = out_data_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hdq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    event_t            ev;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } reply_t;

  // Tracks the slave's line decoder and register file, and holds the replies
  // that each accepted capture request should produce.
  class hdq_reply_scoreboard;
    logic [CAP_W-1:0] glitch_lim;
    logic [CAP_W-1:0] break_lim;
    logic [CAP_W-1:0] one_lim;
    phase_t           phase;
    logic [2:0]       bit_pos;
    logic [7:0]       shifter;
    bit               cmd_seen;
    logic [7:0]       cmd_byte;
    logic [7:0]       regs [128];
    reply_t           pending [$];
    int               errors;

    function new();
      glitch_lim = GLITCH_RESET;
      break_lim  = BREAK_RESET;
      one_lim    = ONE_RESET;
      phase      = PH_BRK_FALL;
      bit_pos    = '0;
      shifter    = '0;
      cmd_seen   = 1'b0;
      cmd_byte   = '0;
      errors     = 0;
      foreach (regs[i]) regs[i] = INIT_IMAGE[i];
    endfunction

    function void set_limit(cfg_index_t idx, logic [CAP_W-1:0] val);
      case (idx)
        CFG_GLITCH: glitch_lim = val;
        CFG_BREAK:  break_lim = val;
        CFG_ONE:    one_lim = val;
        default: ;
      endcase
    endfunction

    function void take_capture(logic [CAP_W-1:0] cap);
      reply_t     r;
      logic [7:0] rx_byte;
      r.ev = EV_NONE;
      r.data = '0;
      if (cap > glitch_lim) begin
        case (phase)
          PH_BRK_FALL: phase = PH_BRK_RISE;
          PH_BRK_RISE: begin
            if (cap > break_lim) begin
              phase = PH_DAT_FALL;
              bit_pos = '0;
              shifter = '0;
              cmd_seen = 1'b0;
              r.ev = EV_BREAK;
            end else begin
              phase = PH_BRK_FALL;
            end
          end
          PH_DAT_FALL: phase = PH_DAT_RISE;
          default: begin
            if (cap <= break_lim) begin
              if (cap < one_lim) shifter[bit_pos] = 1'b1;
              phase = PH_DAT_FALL;
              if (bit_pos != 3'd7) begin
                bit_pos++;
              end else begin
                rx_byte = shifter;
                bit_pos = '0;
                shifter = '0;
                if (!cmd_seen) cmd_byte = rx_byte;
                if ((cmd_byte & WRITE_FLAG) != 8'h00) begin
                  if (cmd_seen) begin
                    regs[cmd_byte[6:0]] = rx_byte;
                    r.ev = EV_WRITTEN;
                    r.data = rx_byte;
                  end else begin
                    r.ev = EV_WCMD;
                  end
                end else begin
                  r.ev = EV_READ;
                  r.data = regs[cmd_byte[6:0]];
                end
                cmd_seen = 1'b1;
              end
            end else begin
              phase = PH_BRK_FALL;
            end
          end
        endcase
      end
      r.addr = cmd_byte[6:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_reply(logic [2:0] ev, logic [ADDR_W-1:0] addr, logic [7:0] data);
      reply_t e;
      if (pending.size() == 0) begin
        report($sformatf("reply with no request waiting: event %0d addr %0d data %0d",
                         ev, addr, data));
        return;
      end
      e = pending.pop_front();
      if (ev !== e.ev)
        report($sformatf("event_res %0d, expected %0d", ev, e.ev));
      if (addr !== e.addr)
        report($sformatf("reg_address %0d, expected %0d", addr, e.addr));
      if (data !== e.data)
        report($sformatf("reg_data 0x%02h, expected 0x%02h", data, e.data));
    endtask
  endclass

  logic clk;
  logic rst_n;

  hdq_in_if  in_chan();
  hdq_out_if out_chan();
  hdq_cfg_if cfg_chan();

  hdq_slave_register_interface uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  hdq_reply_scoreboard board = new();

  int          lim_glitch = int'(GLITCH_RESET);
  int          lim_break  = int'(BREAK_RESET);
  int          lim_one    = int'(ONE_RESET);
  int          sent_count = 0;
  bit          calm_phase = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hdq_slave_register_interface verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
      board.check_reply(out_chan.event_res, out_chan.reg_address, out_chan.reg_data);
  end

  initial begin : reply_sink
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (!calm_phase && $urandom_range(7, 0) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(8, 1)) @(negedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic logic [CAP_W-1:0] pick(int lo, int hi);
    int v;
    if (lo < 0) lo = 0;
    if (lo > 65535) lo = 65535;
    if (hi > 65535) hi = 65535;
    if (hi < lo) hi = lo;
    case ($urandom_range(3, 0))
      0: v = lo;
      1: v = hi;
      default: v = $urandom_range(hi, lo);
    endcase
    return v[CAP_W-1:0];
  endfunction

  function automatic logic [CAP_W-1:0] glitch_val();
    return pick(0, lim_glitch);
  endfunction

  function automatic logic [CAP_W-1:0] edge_val();
    return pick(lim_glitch + 1, 65535);
  endfunction

  function automatic logic [CAP_W-1:0] break_val();
    return pick(lim_break + 1, 65535);
  endfunction

  function automatic logic [CAP_W-1:0] bit_val(bit one);
    int lo;
    lo = lim_glitch + 1;
    if (one) return pick(lo, (lim_one - 1 < lim_break) ? lim_one - 1 : lim_break);
    return pick((lim_one > lo) ? lim_one : lo, lim_break);
  endfunction

  task automatic send_capture(input logic [CAP_W-1:0] cap);
    if (!calm_phase && $urandom_range(7, 0) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.capture_us <= cap;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    board.take_capture(cap);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input cfg_index_t idx, input logic [CAP_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    board.set_limit(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_limits(input int g, input int b, input int o);
    write_limit(CFG_GLITCH, g[CAP_W-1:0]);
    write_limit(CFG_BREAK, b[CAP_W-1:0]);
    write_limit(CFG_ONE, o[CAP_W-1:0]);
    cfg_chan.valid <= 1'b0;
    lim_glitch = g;
    lim_break = b;
    lim_one = o;
  endtask

  task automatic send_bits(input logic [7:0] value, input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19, 0) == 0) send_capture(glitch_val());
      send_capture(edge_val());
      send_capture(bit_val(value[i]));
    end
  endtask

  task automatic send_frame();
    logic [7:0] cmd;
    int         nbytes;
    cmd[7] = 1'($urandom_range(1, 0));
    cmd[6:0] = ($urandom_range(3, 0) == 0) ? 7'($urandom_range(127, 0))
                                           : 7'($urandom_range(7, 0));
    nbytes = int'($urandom_range(3, 0));
    send_capture(edge_val());
    send_capture(break_val());
    send_bits(cmd, 8);
    repeat (nbytes) send_bits(8'($urandom_range(255, 0)), 8);
  endtask

  task automatic send_broken_frame();
    send_capture(edge_val());
    if ($urandom_range(1, 0) == 0) begin
      send_capture(pick(lim_glitch + 1, lim_break));
    end else begin
      send_capture(break_val());
      send_bits(8'($urandom_range(255, 0)), int'($urandom_range(7, 0)));
      send_capture(edge_val());
      send_capture(break_val());
    end
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      case ($urandom_range(9, 0))
        7: repeat ($urandom_range(6, 1)) send_capture(pick(0, 65535));
        8: send_broken_frame();
        9: send_capture(glitch_val());
        default: send_frame();
      endcase
    end
  endtask

  task automatic run_directed();
    logic [CAP_W-1:0] seq [25];
    // Glitches at and below the limit, a short break, a real break, then a
    // read of address 7 with a glitch inside it, and an overlong data pulse.
    seq = '{16'd0, 16'd10, 16'd11, 16'd190, 16'd65535, 16'd191,
            16'd11, 16'd49, 16'd65535, 16'd11, 16'd40, 16'd30, 16'd5,
            16'd12, 16'd50, 16'd200, 16'd190, 16'd15, 16'd100, 16'd25, 16'd120,
            16'd33, 16'd190, 16'd11, 16'd191};
    foreach (seq[i]) send_capture(seq[i]);
  endtask

  initial begin : stimulus
    int g;
    int b;
    in_chan.valid = 1'b0;
    in_chan.capture_us = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_GLITCH;
    cfg_chan.data = '0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    settle();

    apply_limits(10, 190, 50);
    hold_off_req = 1'b1;
    send_frame();
    send_frame();
    run_traffic(30);
    settle();

    apply_limits(0, 65534, 65535);
    run_traffic(30);
    settle();

    apply_limits(65535, 65535, 0);
    run_traffic(10);
    settle();

    apply_limits(0, 0, 0);
    run_traffic(10);
    settle();

    repeat (3) begin
      g = int'($urandom_range(60, 0));
      b = g + int'($urandom_range(3000, 20));
      apply_limits(g, b, int'($urandom_range(b + 1, g + 1)));
      run_traffic(40);
      settle();
    end

    calm_phase = 1'b1;
    apply_limits(10, 190, 50);
    run_traffic(30);
    settle();

    if (board.errors == 0) begin
      $display("hdq_slave_register_interface verification clean");
    end else begin
      $display("hdq_slave_register_interface verification failed");
    end
    $finish;
  end

endmodule
